>>> sv/apsc_pkg.sv
// Shared types and constants of the accelerometer peak step counter.
package apsc_pkg;

    // Field widths
    localparam int AXIS_W  = 16;
    localparam int MAG_W   = 16;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 32;
    localparam int RAD_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Sequencer step counts
    localparam int CNT_W      = 4;
    localparam logic [CNT_W-1:0] SQ_LAST   = 4'd3;
    localparam logic [CNT_W-1:0] ROOT_LAST = 4'd15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INT  = 3'd4;

    // Configuration reset values
    localparam logic [CFG_DATA_W-1:0] MIN_INT_RST = 16'd200;
    localparam logic [CFG_DATA_W-1:0] MAX_INT_RST = 16'd2000;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT,
        ST_WINDOW,
        ST_AVERAGE,
        ST_DETECT,
        ST_OUTPUT
    } t_state;

endpackage

>>> sv/accel_peak_step_counter.sv
// Step counter top level: magnitude, moving average, hysteresis peak and interval check.
// Clear and disabled items skip the squaring, root and window steps.
// Throughput: one item at a time: shared squaring multiplier, bit-serial square root
//   (one root bit per cycle), then window, average, detect and output steps. The next
//   item is accepted while the previous result waits.
// Reset (synchronous, active low) clears state and configuration; intervals go to 200/2000 ms.
module accel_peak_step_counter
    import apsc_pkg::*;
#(
    parameter int AVERAGE_TAPS = 4
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_kind,
    input  logic signed [AXIS_W-1:0]  i_accel_x,
    input  logic signed [AXIS_W-1:0]  i_accel_y,
    input  logic signed [AXIS_W-1:0]  i_accel_z,
    input  logic [STAMP_W-1:0]        i_timestamp_ms,
    // output channel
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [COUNT_W-1:0]        o_step_count,
    output logic                      o_step_counted,
    output logic                      o_peak_seen,
    output logic [MAG_W-1:0]          o_filtered_magnitude,
    // configuration write channel
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data
);

    // Window sizing and reciprocal for the exact floor average
    localparam int SLOT_W = $clog2(AVERAGE_TAPS);
    localparam int SUM_W  = MAG_W + SLOT_W;
    localparam int SHIFT  = SUM_W + SLOT_W;
    localparam logic [SHIFT-1:0] RECIP =
        SHIFT'(((64'd1 << SHIFT) + 64'(AVERAGE_TAPS) - 64'd1) / 64'(AVERAGE_TAPS));
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVERAGE_TAPS - 1);

    // Sequencer
    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;

    // Configuration
    logic             r_enable;
    logic [MAG_W-1:0] r_high_thr, r_low_thr;
    logic [15:0]      r_min_int, r_max_int;

    // Item registers
    logic                  r_sample;
    logic [3*AXIS_W-1:0]   r_axes;
    logic [STAMP_W-1:0]    r_stamp;

    // Magnitude datapath
    logic [2*AXIS_W-1:0]   r_prod;
    logic [RAD_W-1:0]      r_rad;
    logic [MAG_W:0]        r_rem;
    logic [MAG_W-1:0]      r_root;

    // Window and detector state
    logic [MAG_W-1:0]      r_hist [AVERAGE_TAPS];
    logic [SLOT_W-1:0]     r_slot;
    logic [SUM_W-1:0]      r_win_sum;
    logic [MAG_W-1:0]      r_avg;
    logic                  r_armed;
    logic [STAMP_W-1:0]    r_last;
    logic [STAMP_W-1:0]    r_interval;
    logic [COUNT_W-1:0]    r_steps;

    // Pending result and output register
    logic [COUNT_W-1:0]    r_res_count;
    logic                  r_res_counted, r_res_peak;
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_out_count;
    logic                  r_out_counted, r_out_peak;
    logic [MAG_W-1:0]      r_out_avg;

    logic in_take, out_free;

    // Handshake outputs
    always_comb begin
        o_stall     = (r_state != ST_IDLE);
        o_cfg_ready = 1'b1;
        o_valid     = r_out_valid;
    end

    assign in_take  = i_valid && !o_stall;
    assign out_free = !r_out_valid || !i_stall;

    assign o_step_count         = r_out_count;
    assign o_step_counted       = r_out_counted;
    assign o_peak_seen          = r_out_peak;
    assign o_filtered_magnitude = r_out_avg;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_take) begin
                    n_state = (i_kind == KIND_SAMPLE && r_enable) ? ST_SQUARE : ST_AVERAGE;
                end
            end
            ST_SQUARE:  if (r_cnt == SQ_LAST) n_state = ST_ROOT;
            ST_ROOT:    if (r_cnt == ROOT_LAST) n_state = ST_WINDOW;
            ST_WINDOW:  n_state = ST_AVERAGE;
            ST_AVERAGE: n_state = ST_DETECT;
            ST_DETECT:  n_state = ST_OUTPUT;
            ST_OUTPUT:  if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Step counter for squaring and root phases
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (r_state != n_state) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_high_thr <= '0;
            r_low_thr  <= '0;
            r_min_int  <= MIN_INT_RST;
            r_max_int  <= MAX_INT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_ENABLE:   r_enable   <= i_cfg_data[0];
                CFG_HIGH_THR: r_high_thr <= i_cfg_data;
                CFG_LOW_THR:  r_low_thr  <= i_cfg_data;
                CFG_MIN_INT:  r_min_int  <= i_cfg_data;
                CFG_MAX_INT:  r_max_int  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the input beat
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_sample <= (i_kind == KIND_SAMPLE) && r_enable;
            r_stamp  <= i_timestamp_ms;
        end
    end

    // Squaring: axes shift through one 16x16 multiplier, sum accumulates behind it
    logic [AXIS_W-1:0] cur_axis, abs_axis;
    assign cur_axis = r_axes[AXIS_W-1:0];
    assign abs_axis = cur_axis[AXIS_W-1] ? (~cur_axis + 1'b1) : cur_axis;

    // Root step: two radicand bits enter the remainder, one root bit leaves
    logic [MAG_W+2:0] rem_in, trial, rem_diff;
    assign rem_in   = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign trial    = {1'b0, r_root, 2'b01};
    assign rem_diff = rem_in - trial;

    always_ff @(posedge i_clk) begin
        priority if (in_take) begin
            r_axes <= {i_accel_z, i_accel_y, i_accel_x};
            r_rad  <= '0;
        end else if (r_state == ST_SQUARE) begin
            r_axes <= {{AXIS_W{1'b0}}, r_axes[3*AXIS_W-1:AXIS_W]};
            r_prod <= abs_axis * abs_axis;
            if (r_cnt != '0) begin
                r_rad <= r_rad + r_prod;
            end
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_state == ST_ROOT) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            if (rem_in >= trial) begin
                r_rem  <= rem_diff[MAG_W:0];
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_in[MAG_W:0];
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
    end

    // Moving-average window with running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < AVERAGE_TAPS; k++) begin
                r_hist[k] <= '0;
            end
            r_slot    <= '0;
            r_win_sum <= '0;
        end else if (r_state == ST_WINDOW) begin
            r_hist[r_slot] <= r_root;
            r_win_sum      <= r_win_sum - SUM_W'(r_hist[r_slot]) + SUM_W'(r_root);
            r_slot         <= (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
        end
    end

    // Floor average by reciprocal multiply; interval since last peak
    logic [SUM_W+SHIFT-1:0] avg_prod;
    assign avg_prod = r_win_sum * RECIP;

    always_ff @(posedge i_clk) begin
        if (r_state == ST_AVERAGE) begin
            r_avg      <= avg_prod[SHIFT +: MAG_W];
            r_interval <= r_stamp - r_last;
        end
    end

    // Hysteresis detector and interval window
    logic fire, arm, in_window;
    assign arm       = r_sample && (r_avg > r_high_thr) && !r_armed;
    assign fire      = r_sample && !arm && (r_avg < r_low_thr) && r_armed;
    assign in_window = (r_interval >= {16'd0, r_min_int}) &&
                       (r_interval <= {16'd0, r_max_int});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= 1'b0;
            r_last  <= '0;
            r_steps <= '0;
        end else if (in_take && i_kind == KIND_CLEAR) begin
            r_steps <= '0;
        end else if (r_state == ST_DETECT) begin
            if (arm) begin
                r_armed <= 1'b1;
            end
            if (fire) begin
                r_armed <= 1'b0;
                r_last  <= r_stamp;
                if (in_window) begin
                    r_steps <= r_steps + 1'b1;
                end
            end
        end
    end

    // Pending result
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DETECT) begin
            r_res_count   <= (fire && in_window) ? r_steps + 1'b1 : r_steps;
            r_res_counted <= fire && in_window;
            r_res_peak    <= fire;
        end
    end

    // Output register: loads when empty or when its beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_OUTPUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUTPUT && out_free) begin
            r_out_count   <= r_res_count;
            r_out_counted <= r_res_counted;
            r_out_peak    <= r_res_peak;
            r_out_avg     <= r_avg;
        end
    end

    // Checks
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUTPUT && out_free) |=> r_out_valid)
        else $error("result beat not presented after load");

    a_count_needs_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_counted || r_out_peak))
        else $error("step counted without a peak");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_LAST)
        else $error("window slot out of range");

    a_root_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT) |=> (r_rem <= {r_root, 1'b0}))
        else $error("root remainder exceeds bound");

    a_busy_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE && r_state != ST_OUTPUT) |=> (r_state != ST_IDLE))
        else $error("sequencer skipped the output step");

endmodule
